@@ rtl/bts_pkg.sv @@
// Shared types and codes of the bilinear texture sampler.
`timescale 1ns / 1ps
package bts_pkg;

  // operation codes of an input request
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // configuration register indexes
  localparam logic [2:0] REG_TEX_WIDTH  = 3'd0;
  localparam logic [2:0] REG_TEX_HEIGHT = 3'd1;
  localparam logic [2:0] REG_ALPHA_GAIN = 3'd2;
  localparam logic [2:0] REG_RED_GAIN   = 3'd3;
  localparam logic [2:0] REG_GREEN_GAIN = 3'd4;
  localparam logic [2:0] REG_BLUE_GAIN  = 3'd5;

  localparam int SIZE_W  = 9;
  localparam int GAIN_W  = 16;
  localparam int COLOR_W = 32;
  localparam int PIX_W   = 16;
  localparam int CHAN_W  = 8;

  // classification of a request as it travels from front to back
  typedef struct packed {
    logic       is_load;
    logic [1:0] okx;      // lower / upper column inside the texture
    logic [1:0] oky;      // lower / upper row inside the texture
  } bts_ctl_t;

  localparam int CTL_W = $bits(bts_ctl_t);

endpackage

@@ rtl/bilinear_texture_sampler.sv @@
// Top level of the bilinear texture sampler: config registers, front, queue, back.
`timescale 1ns / 1ps
// One request per clock: a request is taken at each edge with start high and busy
// low, and busy stays low in normal use because the back end drains the queue every
// cycle. Loads write one ARGB texel into a store of four parity banks (one read port
// each), so a sample reads its four neighbours together. A sample inside 0..1 gives
// one result strobe (done_o); its registered steps in order are the coordinate
// multiply, the queue, store read, channel sums, gain multiply and saturation.
// Loads and out-of-range samples give no result. The store is not cleared at
// reset; texels must be loaded before they are sampled.
module bilinear_texture_sampler
  import bts_pkg::*;
#(
  parameter int MAX_SIDE_LOG2   = 8,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         operation_i,
  input  logic [7:0]                   texel_column_i,
  input  logic [7:0]                   texel_row_i,
  input  logic [COLOR_W-1:0]           texel_color_i,
  input  logic [COORD_FRAC_BITS:0]     u_coord_i,
  input  logic [COORD_FRAC_BITS:0]     v_coord_i,
  input  logic signed [PIX_W-1:0]      pixel_x_i,
  input  logic signed [PIX_W-1:0]      pixel_y_i,
  input  logic                         cfg_we_i,
  input  logic [2:0]                   cfg_index_i,
  input  logic [GAIN_W-1:0]            cfg_data_i,
  output logic                         done_o,
  output logic signed [PIX_W-1:0]      out_x_o,
  output logic signed [PIX_W-1:0]      out_y_o,
  output logic [CHAN_W-1:0]            alpha_o,
  output logic [CHAN_W-1:0]            red_o,
  output logic [CHAN_W-1:0]            green_o,
  output logic [CHAN_W-1:0]            blue_o
);

  localparam int S  = MAX_SIDE_LOG2;
  localparam int F  = COORD_FRAC_BITS;
  localparam int QW = CTL_W + 4 * S + 2 * F + COLOR_W + 2 * PIX_W;

  // configuration registers
  logic [SIZE_W-1:0]       width_q, height_q;
  logic [3:0][GAIN_W-1:0]  gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SIZE_W'(256);
      height_q <= SIZE_W'(256);
      gain_q   <= {4{GAIN_W'(256)}};
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_TEX_WIDTH:  width_q   <= cfg_data_i[SIZE_W-1:0];
        REG_TEX_HEIGHT: height_q  <= cfg_data_i[SIZE_W-1:0];
        REG_ALPHA_GAIN: gain_q[0] <= cfg_data_i;
        REG_RED_GAIN:   gain_q[1] <= cfg_data_i;
        REG_GREEN_GAIN: gain_q[2] <= cfg_data_i;
        REG_BLUE_GAIN:  gain_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic accept;
  assign accept = start && !busy;

  // front end
  logic                    f_push;
  bts_ctl_t                f_ctl;
  logic [S-1:0]            f_px0, f_px1, f_py0, f_py1;
  logic [F-1:0]            f_fx, f_fy;
  logic [COLOR_W-1:0]      f_color;
  logic signed [PIX_W-1:0] f_x, f_y;

  bts_front #(.S(S), .F(F)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .op_i     (operation_i),
    .col_i    (texel_column_i),
    .row_i    (texel_row_i),
    .color_i  (texel_color_i),
    .u_i      (u_coord_i),
    .v_i      (v_coord_i),
    .pix_x_i  (pixel_x_i),
    .pix_y_i  (pixel_y_i),
    .width_i  (width_q),
    .height_i (height_q),
    .push_o   (f_push),
    .ctl_o    (f_ctl),
    .px0_o    (f_px0),
    .px1_o    (f_px1),
    .py0_o    (f_py0),
    .py1_o    (f_py1),
    .fx_o     (f_fx),
    .fy_o     (f_fy),
    .color_o  (f_color),
    .pix_x_o  (f_x),
    .pix_y_o  (f_y)
  );

  // queue between front and back
  logic          q_valid, q_full, q_almost_full;
  logic [QW-1:0] q_wdata, q_rdata;

  assign q_wdata = {f_ctl, f_px0, f_px1, f_py0, f_py1, f_fx, f_fy, f_color, f_x, f_y};

  bts_queue #(.W(QW)) u_queue (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (f_push),
    .data_i        (q_wdata),
    .valid_o       (q_valid),
    .data_o        (q_rdata),
    .almost_full_o (q_almost_full),
    .full_o        (q_full)
  );

  assign busy = q_almost_full;

  bts_ctl_t                b_ctl;
  logic [S-1:0]            b_px0, b_px1, b_py0, b_py1;
  logic [F-1:0]            b_fx, b_fy;
  logic [COLOR_W-1:0]      b_color;
  logic signed [PIX_W-1:0] b_x, b_y;
  logic [3:0][CHAN_W-1:0]  chan;

  assign {b_ctl, b_px0, b_px1, b_py0, b_py1, b_fx, b_fy, b_color, b_x, b_y} = q_rdata;

  // back end
  bts_back #(.S(S), .F(F)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .ctl_i   (b_ctl),
    .px0_i   (b_px0),
    .px1_i   (b_px1),
    .py0_i   (b_py0),
    .py1_i   (b_py1),
    .fx_i    (b_fx),
    .fy_i    (b_fy),
    .color_i (b_color),
    .pix_x_i (b_x),
    .pix_y_i (b_y),
    .gain_i  (gain_q),
    .done_o  (done_o),
    .out_x_o (out_x_o),
    .out_y_o (out_y_o),
    .chan_o  (chan)
  );

  assign alpha_o = chan[0];
  assign red_o   = chan[1];
  assign green_o = chan[2];
  assign blue_o  = chan[3];

`ifndef SYNTH
  // the queue must never overflow
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_push |-> !q_full) else $error("queue push while full");

  // every result comes from a sample request taken earlier
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept && (operation_i == OP_SAMPLE), 6))
    else $error("result without a matching sample request");

  // the back end drains every cycle, so busy never rises
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid |=> !q_almost_full) else $error("queue backed up");
`endif

endmodule

@@ rtl/bts_front.sv @@
// Front end: accepts requests, drops out-of-range samples, maps u/v to texel space.
`timescale 1ns / 1ps
module bts_front
  import bts_pkg::*;
#(
  parameter int S = 8,
  parameter int F = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  logic                     op_i,
  input  logic [7:0]               col_i,
  input  logic [7:0]               row_i,
  input  logic [COLOR_W-1:0]       color_i,
  input  logic [F:0]               u_i,
  input  logic [F:0]               v_i,
  input  logic signed [PIX_W-1:0]  pix_x_i,
  input  logic signed [PIX_W-1:0]  pix_y_i,
  input  logic [SIZE_W-1:0]        width_i,
  input  logic [SIZE_W-1:0]        height_i,
  output logic                     push_o,
  output bts_ctl_t                 ctl_o,
  output logic [S-1:0]             px0_o,
  output logic [S-1:0]             px1_o,
  output logic [S-1:0]             py0_o,
  output logic [S-1:0]             py1_o,
  output logic [F-1:0]             fx_o,
  output logic [F-1:0]             fy_o,
  output logic [COLOR_W-1:0]       color_o,
  output logic signed [PIX_W-1:0]  pix_x_o,
  output logic signed [PIX_W-1:0]  pix_y_o
);

  localparam int MW = F + S + 1;
  localparam logic [F:0]    ONE  = {1'b1, {F{1'b0}}};
  localparam logic [MW-1:0] HALF = MW'(1) << (F - 1);
  localparam int SIDE = 1 << S;

  logic [S:0]   wc, hc;
  logic [F-1:0] uw, vw;
  logic         keep;
  logic [MW-1:0] mx_d, my_d;

  logic                    f1_valid_q;
  logic                    f1_load_q;
  logic [MW-1:0]           mx_q, my_q;
  logic [S-1:0]            col_q, row_q;
  logic [COLOR_W-1:0]      color_q;
  logic signed [PIX_W-1:0] pix_x_q, pix_y_q;

  // texture size saturated to the store side
  always_comb begin
    wc = ({23'd0, width_i} > 32'(SIDE)) ? (S+1)'(SIDE) : (S+1)'(width_i);
    hc = ({23'd0, height_i} > 32'(SIDE)) ? (S+1)'(SIDE) : (S+1)'(height_i);
  end

  // classify: coordinate 1.0 wraps to 0, above 1.0 is dropped
  always_comb begin
    uw   = (u_i == ONE) ? '0 : u_i[F-1:0];
    vw   = (v_i == ONE) ? '0 : v_i[F-1:0];
    keep = accept_i && ((op_i == OP_LOAD) || ((u_i <= ONE) && (v_i <= ONE)));
    mx_d = MW'(uw) * MW'(wc);
    my_d = MW'(vw) * MW'(hc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
    end else begin
      f1_valid_q <= keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (keep) begin
      f1_load_q <= (op_i == OP_LOAD);
      mx_q      <= mx_d;
      my_q      <= my_d;
      col_q     <= S'(32'(col_i));
      row_q     <= S'(32'(row_i));
      color_q   <= color_i;
      pix_x_q   <= pix_x_i;
      pix_y_q   <= pix_y_i;
    end
  end

  // neighbour positions, inside tests and fractions
  logic [MW:0]   mxp, myp;
  logic [MW-1:0] mxm, mym, wf, hf;

  always_comb begin
    wf  = MW'(wc) << F;
    hf  = MW'(hc) << F;
    mxp = {1'b0, mx_q} + (MW+1)'(HALF);
    myp = {1'b0, my_q} + (MW+1)'(HALF);
    mxm = mx_q - HALF;
    mym = my_q - HALF;

    ctl_o.is_load = f1_load_q;
    ctl_o.okx[0]  = (mx_q > HALF) && (mxm < wf);
    ctl_o.okx[1]  = (mxp < {1'b0, wf});
    ctl_o.oky[0]  = (my_q > HALF) && (mym < hf);
    ctl_o.oky[1]  = (myp < {1'b0, hf});
    px0_o = mxm[F +: S];
    py0_o = mym[F +: S];
    px1_o = f1_load_q ? col_q : mxp[F +: S];
    py1_o = f1_load_q ? row_q : myp[F +: S];
    fx_o  = mxp[F-1:0];
    fy_o  = myp[F-1:0];
  end

  assign push_o  = f1_valid_q;
  assign color_o = color_q;
  assign pix_x_o = pix_x_q;
  assign pix_y_o = pix_y_q;

endmodule

@@ rtl/bts_queue.sv @@
// Short request queue between the front end and the filter back end.
`timescale 1ns / 1ps
module bts_queue
  import bts_pkg::*;
#(
  parameter int W = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         valid_o,
  output logic [W-1:0] data_o,
  output logic         almost_full_o,
  output logic         full_o
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [PW:0]   cnt_q;
  logic          pop;

  // back end never stalls: pop whenever an entry is present
  assign pop     = (cnt_q != '0);
  assign valid_o = pop;
  assign data_o  = mem_q[rd_q];
  assign full_o  = (cnt_q == (PW+1)'(DEPTH));
  assign almost_full_o = (cnt_q >= (PW+1)'(DEPTH - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop)    rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(push_i) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

@@ rtl/bts_back.sv @@
// Back end: banked texture store, bilinear weighting and gain scaling.
`timescale 1ns / 1ps
module bts_back
  import bts_pkg::*;
#(
  parameter int S = 8,
  parameter int F = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  bts_ctl_t                     ctl_i,
  input  logic [S-1:0]                 px0_i,
  input  logic [S-1:0]                 px1_i,
  input  logic [S-1:0]                 py0_i,
  input  logic [S-1:0]                 py1_i,
  input  logic [F-1:0]                 fx_i,
  input  logic [F-1:0]                 fy_i,
  input  logic [COLOR_W-1:0]           color_i,
  input  logic signed [PIX_W-1:0]      pix_x_i,
  input  logic signed [PIX_W-1:0]      pix_y_i,
  input  logic [3:0][GAIN_W-1:0]       gain_i,
  output logic                         done_o,
  output logic signed [PIX_W-1:0]      out_x_o,
  output logic signed [PIX_W-1:0]      out_y_o,
  output logic [3:0][CHAN_W-1:0]       chan_o
);

  localparam int BAW   = (S > 1) ? 2 * S - 2 : 1;
  localparam int BANK_WORDS = 1 << (2 * S - 2);
  localparam int WW    = 2 * F + 1;
  localparam int SW    = 2 * F + 8;
  localparam int HW    = SW - F;
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

  function automatic logic [BAW-1:0] bank_index(input logic [S-1:0] r, input logic [S-1:0] c);
    bank_index = BAW'((32'(r >> 1) << (S - 1)) | 32'(c >> 1));
  endfunction

  logic rd_en, wr_en;
  assign rd_en = valid_i && !ctl_i.is_load;
  assign wr_en = valid_i && ctl_i.is_load;

  // four banks split by row and column parity: one read each per sample
  logic [COLOR_W-1:0] rd_q [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [COLOR_W-1:0] mem [BANK_WORDS];
    logic [S-1:0]       rsel, csel;
    logic               wsel;

    assign rsel = (py1_i[0] == 1'((b >> 1) & 1)) ? py1_i : py0_i;
    assign csel = (px1_i[0] == 1'(b & 1)) ? px1_i : px0_i;
    assign wsel = ({py1_i[0], px1_i[0]} == 2'(b));

    always_ff @(posedge clk_i) begin
      if (wr_en && wsel) begin
        mem[bank_index(py1_i, px1_i)] <= color_i;
      end
      if (rd_en) begin
        rd_q[b] <= mem[bank_index(rsel, csel)];
      end
    end
  end

  // stage 1: neighbor weights alongside the store read
  logic [F:0]    wx [2];
  logic [F:0]    wy [2];
  logic [WW-1:0] wt_d [4];
  logic [3:0]    nb_d;

  always_comb begin
    wx[0] = ONE - {1'b0, fx_i};
    wx[1] = {1'b0, fx_i};
    wy[0] = ONE - {1'b0, fy_i};
    wy[1] = {1'b0, fy_i};
    for (int n = 0; n < 4; n++) begin
      nb_d[n] = ctl_i.okx[n % 2] && ctl_i.oky[n / 2];
      if (nb_d[n]) begin
        wt_d[n] = WW'(wx[n % 2] * wy[n / 2]);
      end else begin
        wt_d[n] = '0;
      end
    end
  end

  logic                    b1_valid_q, b2_valid_q, b3_valid_q;
  logic [WW-1:0]           wt_q [4];
  logic [3:0]              nb_q;
  logic                    xpar_q, ypar_q;
  logic signed [PIX_W-1:0] b1_x_q, b1_y_q, b2_x_q, b2_y_q, b3_x_q, b3_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q <= 1'b0;
      b2_valid_q <= 1'b0;
      b3_valid_q <= 1'b0;
      done_o     <= 1'b0;
    end else begin
      b1_valid_q <= rd_en;
      b2_valid_q <= b1_valid_q;
      b3_valid_q <= b2_valid_q;
      done_o     <= b3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      wt_q   <= wt_d;
      nb_q   <= nb_d;
      xpar_q <= px1_i[0];
      ypar_q <= py1_i[0];
      b1_x_q <= pix_x_i;
      b1_y_q <= pix_y_i;
    end
  end

  // stage 2: weighted channel sums over the four neighbors; a neighbor outside
  // the texture contributes nothing, whatever its bank returned
  logic [SW-1:0]      sum_d [4];
  logic [SW-1:0]      sum_q [4];
  logic [COLOR_W-1:0] tex;
  logic [1:0]         bsel;

  always_comb begin
    tex  = '0;
    bsel = '0;
    for (int c = 0; c < 4; c++) sum_d[c] = '0;
    for (int n = 0; n < 4; n++) begin
      bsel = {((n / 2) == 1) ? ypar_q : ~ypar_q, ((n % 2) == 1) ? xpar_q : ~xpar_q};
      tex  = nb_q[n] ? rd_q[bsel] : '0;
      for (int c = 0; c < 4; c++) begin
        sum_d[c] = sum_d[c] + SW'(tex[24 - 8 * c +: 8] * wt_q[n]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b1_valid_q) begin
      sum_q  <= sum_d;
      b2_x_q <= b1_x_q;
      b2_y_q <= b1_y_q;
    end
  end

  // stage 3: gain products on the integer and fraction halves
  logic [HW+GAIN_W-1:0] hg_q [4];
  logic [F+GAIN_W-1:0]  lg_q [4];

  always_ff @(posedge clk_i) begin
    if (b2_valid_q) begin
      for (int c = 0; c < 4; c++) begin
        hg_q[c] <= sum_q[c][SW-1:F] * gain_i[c];
        lg_q[c] <= sum_q[c][F-1:0] * gain_i[c];
      end
      b3_x_q <= b2_x_q;
      b3_y_q <= b2_y_q;
    end
  end

  // stage 4: combine, truncate and saturate
  logic [HW+GAIN_W:0] t_d [4];
  logic [HW+GAIN_W-F-8:0] r_d [4];
  logic [3:0][CHAN_W-1:0] chan_d;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      t_d[c] = (HW+GAIN_W+1)'(hg_q[c]) + (HW+GAIN_W+1)'(lg_q[c] >> F);
      r_d[c] = t_d[c][HW+GAIN_W:F+8];
      chan_d[c] = (r_d[c] > 255) ? 8'hFF : r_d[c][7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (b3_valid_q) begin
      chan_o  <= chan_d;
      out_x_o <= b3_x_q;
      out_y_o <= b3_y_q;
    end
  end

endmodule
